FILE: design/nqueens_constellation_counter_unit_assert.svh
// ----------------------------------------------------------------------------
// N-queens constellation counter assertion macros
// Short forms for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef NQUEENS_CONSTELLATION_COUNTER_UNIT_ASSERT_SVH
`define NQUEENS_CONSTELLATION_COUNTER_UNIT_ASSERT_SVH

// same-cycle implication
`define NQCC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NQCC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/nqcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens constellation counter package
// Shared constants, controller state and command/status types.
// ----------------------------------------------------------------------------
package nqcc_pkg;

   localparam int unsigned MAX_BOARD   = 32;
   localparam int unsigned COUNT_W     = 40;
   localparam logic [5:0]  BOARD_RESET = 6'd16;
   localparam logic [5:0]  BOARD_MIN   = 6'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_INIT,
      ST_SEARCH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic load;
      logic build;
      logic init;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic build_last;
      logic search_done;
   } status_type;

   // clamp the board size register into the supported range
   function automatic logic [5:0] board_n(input logic [5:0] size);
      logic [5:0] n;
      n = size;
      if (n < BOARD_MIN) n = BOARD_MIN;
      if (n > 6'(MAX_BOARD)) n = 6'(MAX_BOARD);
      return n;
   endfunction

endpackage

FILE: design/nqcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens constellation counter controller
// Sequences load, table build, search init, search steps and the result.
// ----------------------------------------------------------------------------
module nqcc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_skip,
   input  nqcc_pkg::status_type status,
   output nqcc_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 rsp_valid
);

   nqcc_pkg::state_type state_ff;
   nqcc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nqcc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nqcc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = req_skip ? nqcc_pkg::ST_RESPOND : nqcc_pkg::ST_BUILD;
            end
         end
         nqcc_pkg::ST_BUILD: begin
            if (status.build_last) state_in = nqcc_pkg::ST_INIT;
         end
         nqcc_pkg::ST_INIT: begin
            state_in = nqcc_pkg::ST_SEARCH;
         end
         nqcc_pkg::ST_SEARCH: begin
            if (status.search_done) state_in = nqcc_pkg::ST_RESPOND;
         end
         nqcc_pkg::ST_RESPOND: begin
            state_in = nqcc_pkg::ST_IDLE;
         end
         default: begin
            state_in = nqcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = (state_ff != nqcc_pkg::ST_IDLE);
      rsp_valid = (state_ff == nqcc_pkg::ST_RESPOND);
      unique case (state_ff)
         nqcc_pkg::ST_IDLE:    cmd.load  = start;
         nqcc_pkg::ST_BUILD:   cmd.build = 1'b1;
         nqcc_pkg::ST_INIT:    cmd.init  = 1'b1;
         nqcc_pkg::ST_SEARCH:  cmd.step  = ~status.search_done;
         nqcc_pkg::ST_RESPOND: cmd       = '0;
         default:              cmd       = '0;
      endcase
   end

endmodule

FILE: design/nqcc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens constellation counter datapath
// Board size register, row blocking table, placement stack, search registers.
// ----------------------------------------------------------------------------
module nqcc_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [5:0]                        csr_write_data,
   input  nqcc_pkg::cmd_type                 cmd,
   output nqcc_pkg::status_type              status,
   input  logic [31:0]                       req_left_diag,
   input  logic [31:0]                       req_right_diag,
   input  logic [31:0]                       req_columns,
   input  logic [4:0]                        req_start_row,
   input  logic [4:0]                        req_last_row_column,
   input  logic [4:0]                        req_left_border_row,
   input  logic [4:0]                        req_right_border_row,
   output logic [nqcc_pkg::COUNT_W-1:0]      solution_count
);

   localparam int unsigned CW = nqcc_pkg::COUNT_W;

   logic [5:0]    board_size_ff;
   logic [5:0]    row_ff, row_in;
   logic [4:0]    start_ff, start_in;
   logic [63:0]   ld_ff, ld_in;
   logic [63:0]   rd_ff, rd_in;
   logic [31:0]   col_ff, col_in;
   logic [31:0]   fr_ff, fr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [4:0]    build_idx_ff, build_idx_in;
   logic [4:0]    k_ff, k_in;
   logic [4:0]    l_ff, l_in;
   logic [31:0]   ldb_ff, ldb_in;
   logic [31:0]   rdb_ff, rdb_in;
   logic [31:0]   ldt_ff, ldt_in;
   logic [31:0]   rdt_ff, rdt_in;

   logic [31:0]   tab_ff   [32];
   logic [63:0]   stack_ff [32];

   logic [5:0]    n;
   logic [4:0]    n_m1;
   logic [31:0]   big;
   logic [4:0]    k_shift;
   logic [31:0]   ldt_new, rdt_new, ld_init, rd_init, col_init;
   logic [4:0]    a_shift;
   logic [31:0]   tab_entry;
   logic [5:0]    row_up, row_dn;
   logic [31:0]   tab_cur, tab_up;
   logic [31:0]   q, q_dn;
   logic [63:0]   ld_up, rd_up, pop;
   logic [31:0]   col_up;
   logic          at_last;
   logic          push;

   assign n      = nqcc_pkg::board_n(board_size_ff);
   assign n_m1   = 5'(n - 6'd1);
   assign big    = 32'd1 << n_m1;

   // load-time masks from the border queens
   assign k_shift  = 5'(n_m1 - req_left_border_row);
   assign ldt_new  = big >> req_left_border_row;
   assign rdt_new  = 32'd1 << req_right_border_row;
   assign ld_init  = req_left_diag & ~(ldt_new << req_start_row);
   assign rd_init  = (req_right_border_row != n_m1) ?
                     (req_right_diag & ~(rdt_new >> req_start_row)) : req_right_diag;
   assign col_init = ~(big - 32'd2) ^ req_columns;

   // one blocking table row per build cycle
   assign a_shift = 5'(n_m1 - build_idx_ff);
   always_comb begin
      if ({1'b0, build_idx_ff} >= n) begin
         tab_entry = '0;
      end else if ((build_idx_ff == k_ff) || (build_idx_ff == l_ff)) begin
         tab_entry = ((build_idx_ff == k_ff) ? ~big : 32'd0) +
                     ((build_idx_ff == l_ff) ? ~32'd1 : 32'd0);
      end else begin
         tab_entry = (ldb_ff >> a_shift) | (rdb_ff << a_shift) |
                     (ldt_ff << build_idx_ff) | (rdt_ff >> build_idx_ff) | big | 32'd1;
      end
   end

   // search step
   assign row_up  = row_ff + 6'd1;
   assign row_dn  = row_ff - 6'd1;
   assign tab_cur = row_ff[5] ? 32'd0 : tab_ff[row_ff[4:0]];
   assign tab_up  = row_up[5] ? 32'd0 : tab_ff[row_up[4:0]];
   assign q       = fr_ff & (~fr_ff + 32'd1);
   assign ld_up   = (ld_ff | {32'd0, q}) << 1;
   assign rd_up   = (rd_ff | {q, 32'd0}) >> 1;
   assign col_up  = col_ff ^ q;
   assign pop     = stack_ff[row_dn[4:0]];
   assign q_dn    = pop[31:0];
   assign at_last = (row_ff == (n - 6'd2));
   assign push    = cmd.step && (fr_ff != 32'd0) && !at_last;

   assign status.build_last  = &build_idx_ff;
   assign status.search_done = (fr_ff == 32'd0) && (row_ff == {1'b0, start_ff});
   assign solution_count     = count_ff;

   always_comb begin
      row_in       = row_ff;
      start_in     = start_ff;
      ld_in        = ld_ff;
      rd_in        = rd_ff;
      col_in       = col_ff;
      fr_in        = fr_ff;
      count_in     = count_ff;
      build_idx_in = build_idx_ff;
      k_in         = k_ff;
      l_in         = l_ff;
      ldb_in       = ldb_ff;
      rdb_in       = rdb_ff;
      ldt_in       = ldt_ff;
      rdt_in       = rdt_ff;
      if (cmd.load) begin
         start_in     = req_start_row;
         row_in       = {1'b0, req_start_row};
         ld_in        = {32'd0, ld_init};
         rd_in        = {rd_init, 32'd0};
         col_in       = col_init;
         count_in     = '0;
         build_idx_in = '0;
         k_in         = req_left_border_row;
         l_in         = req_right_border_row;
         ldt_in       = ldt_new;
         rdt_in       = rdt_new;
         ldb_in       = (big >> req_last_row_column) | (big >> req_right_border_row);
         rdb_in       = (big >> req_last_row_column) | (big >> k_shift);
      end
      if (cmd.build) begin
         build_idx_in = build_idx_ff + 5'd1;
      end
      if (cmd.init) begin
         fr_in = ~(col_ff | tab_cur | ld_ff[31:0] | rd_ff[63:32]);
      end
      if (cmd.step) begin
         if (fr_ff != 32'd0) begin
            if (at_last) begin
               if (~&count_ff) count_in = count_ff + CW'(1);
               fr_in = '0;
            end else begin
               row_in = row_up;
               ld_in  = ld_up;
               rd_in  = rd_up;
               col_in = col_up;
               fr_in  = ~(tab_up | col_up | ld_up[31:0] | rd_up[63:32]);
            end
         end else begin
            // back out one row
            row_in = row_dn;
            ld_in  = (ld_ff >> 1) ^ {32'd0, q_dn};
            rd_in  = (rd_ff << 1) ^ {q_dn, 32'd0};
            col_in = col_ff ^ q_dn;
            fr_in  = pop[63:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff <= nqcc_pkg::BOARD_RESET;
      end else if (csr_write_enable) begin
         board_size_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      start_ff     <= start_in;
      ld_ff        <= ld_in;
      rd_ff        <= rd_in;
      col_ff       <= col_in;
      fr_ff        <= fr_in;
      count_ff     <= count_in;
      build_idx_ff <= build_idx_in;
      k_ff         <= k_in;
      l_ff         <= l_in;
      ldb_ff       <= ldb_in;
      rdb_ff       <= rdb_in;
      ldt_ff       <= ldt_in;
      rdt_ff       <= rdt_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.build) begin
         tab_ff[build_idx_ff] <= tab_entry;
      end
      if (push) begin
         stack_ff[row_ff[4:0]] <= {fr_ff ^ q, q};
      end
   end

endmodule

FILE: design/nqueens_constellation_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens constellation counter unit
// Counts board completions for one start constellation by bitmask backtracking.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel: an item (skip flag, diagonal and column masks, start row,
//    border queens j/k/l) is taken at a rising edge with start high and busy
//    low. busy stays high until the item's result has been shown.
//  - Result channel: rsp_valid is high for exactly one cycle with
//    rsp_solution_count (saturating at 2^40-1). The receiver cannot stall;
//    the result is taken at the edge that ends that cycle.
//  - Config: csr_write_enable/csr_write_data write the board size N (clamped
//    to 5..32). Write it only while busy is low.
//  - Sequence: a skipped item answers in the cycle after acceptance with 0.
//    Otherwise the BUILD state writes all 32 rows of the per-row blocking
//    table, the INIT state seeds the first row's free slots, then the search
//    takes one place, count or backtrack step per cycle (S steps) until it
//    sees that it is finished, then the RESPOND state shows the result.
//    S is set by the search tree of the constellation.
//  - Reset (synchronous, active high) returns the controller to idle and the
//    board size to 16; an item in flight is dropped without a result.
// ----------------------------------------------------------------------------
module nqueens_constellation_counter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_skip,
   input  logic [31:0] req_left_diag,
   input  logic [31:0] req_right_diag,
   input  logic [31:0] req_columns,
   input  logic [4:0]  req_start_row,
   input  logic [4:0]  req_last_row_column,
   input  logic [4:0]  req_left_border_row,
   input  logic [4:0]  req_right_border_row,
   output logic        rsp_valid,
   output logic [nqcc_pkg::COUNT_W-1:0] rsp_solution_count,
   input  logic        csr_write_enable,
   input  logic [5:0]  csr_write_data
);

   // controller -> datapath commands, datapath -> controller status
   nqcc_pkg::cmd_type    cmd;
   nqcc_pkg::status_type status;

   nqcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_skip  (req_skip),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // the count register is cleared on load, so a skipped item reports zero
   nqcc_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .cmd                  (cmd),
      .status               (status),
      .req_left_diag        (req_left_diag),
      .req_right_diag       (req_right_diag),
      .req_columns          (req_columns),
      .req_start_row        (req_start_row),
      .req_last_row_column  (req_last_row_column),
      .req_left_border_row  (req_left_border_row),
      .req_right_border_row (req_right_border_row),
      .solution_count       (rsp_solution_count)
   );

endmodule

FILE: design/nqcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// N-queens constellation counter port checker
// Checks item acceptance and result timing seen at the unit's ports.
// ----------------------------------------------------------------------------
`include "nqueens_constellation_counter_unit_assert.svh"

module nqcc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_skip,
   input logic                         rsp_valid,
   input logic [nqcc_pkg::COUNT_W-1:0] rsp_solution_count
);

   `NQCC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after accept")
   `NQCC_ASSERT_IMPLY(a_rsp_in_item, clock, reset, rsp_valid, busy, "result outside an item")
   `NQCC_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `NQCC_ASSERT_NEXT(a_skip_zero, clock, reset, start && !busy && req_skip, rsp_valid && (rsp_solution_count == '0), "skipped item not answered with zero")

endmodule

bind nqueens_constellation_counter_unit nqcc_checker u_nqcc_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_skip           (req_skip),
   .rsp_valid          (rsp_valid),
   .rsp_solution_count (rsp_solution_count)
);
